// ===== hdl/p2r_pkg.sv =====
// Shared types, constants and a helper function of the pixel to RGB888 converter.
package p2r_pkg;

   // Word and channel geometry
   localparam int WORD_W    = 32;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int POS_W     = 5;
   localparam int TOP_W     = 7;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = WORD_W / DIV_BITS;

   // Channel slots
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MASK        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MASK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MASK       = 3'd4;

   localparam logic [2:0]        BPP_RESET        = 3'd4;
   localparam logic [WORD_W-1:0] RED_MASK_RESET   = 32'h00FF_0000;
   localparam logic [WORD_W-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
   localparam logic [WORD_W-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;

   // Item opcodes
   localparam logic OP_PIXEL         = 1'b0;
   localparam logic OP_PALETTE_WRITE = 1'b1;

   // Per-item flags and early results that ride along the pipeline
   typedef struct packed {
      logic                             pal;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]  rgb;
      logic [NUM_CHAN-1:0]              zero;
      logic [NUM_CHAN-1:0]              wide;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]  wres;
   } side_type;

   // Bit position of a one-hot word (zero gives zero)
   function automatic logic [POS_W-1:0] onehot_to_pos(input logic [WORD_W-1:0] oh);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (oh[i]) begin
            pos = pos | POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== hdl/p2r_ifaces.sv =====
// Valid/ready channel interfaces for pixel requests and RGB responses.
interface p2r_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] pixel_word;
   logic [7:0]  entry_index;
   logic [7:0]  entry_red;
   logic [7:0]  entry_green;
   logic [7:0]  entry_blue;

   modport source (output valid, opcode, pixel_word, entry_index, entry_red, entry_green,
                   entry_blue, input ready);
   modport sink   (input valid, opcode, pixel_word, entry_index, entry_red, entry_green,
                   entry_blue, output ready);
endinterface

interface p2r_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== hdl/p2r_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module p2r_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, hold data while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/pixel_to_rgb888_converter_top.sv =====
// Top level of the pixel to RGB888 converter: mask decode and palette lookup pipeline.
//
//   port      dir  kind         word carried
//   req_ch    in   valid/ready  opcode, pixel_word, entry_index, entry_red/green/blue
//   rsp_ch    out  valid/ready  red_out, green_out, blue_out
//   csr_*     in   write only   csr_we, csr_index, csr_wdata
//
// One word enters per cycle while rsp_ch does not stall. A pixel word passes in turn through
// the mask decode (4 stages), the dividend stage, the radix-16 divider that scales narrow
// fields (8 stages) and the output register before it is presented on rsp_ch.
// Palette-write words update the palette RAM at acceptance and give no response.
// Synchronous reset empties the pipeline and restores the registers; the palette is
// undefined until written. A stall on rsp_ch freezes every stage, and req_ch.ready drops
// with it.
module pixel_to_rgb888_converter_top #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   p2r_req_if.sink                          req_ch,
   p2r_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [p2r_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p2r_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int NC     = p2r_pkg::NUM_CHAN;
   localparam int WW     = p2r_pkg::WORD_W;
   localparam int CW     = p2r_pkg::CHAN_W;
   localparam int PW     = p2r_pkg::POS_W;
   localparam int TW     = p2r_pkg::TOP_W;
   localparam int DS     = p2r_pkg::DIV_STEPS;
   localparam int DB     = p2r_pkg::DIV_BITS;

   // ---------------------------------------------------------------- registers
   logic                      mode_ff;
   logic [2:0]                bpp_ff;
   logic [NC-1:0][WW-1:0]     mask_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= 1'b0;
         bpp_ff           <= p2r_pkg::BPP_RESET;
         mask_ff[p2r_pkg::CH_RED]   <= p2r_pkg::RED_MASK_RESET;
         mask_ff[p2r_pkg::CH_GREEN] <= p2r_pkg::GREEN_MASK_RESET;
         mask_ff[p2r_pkg::CH_BLUE]  <= p2r_pkg::BLUE_MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            p2r_pkg::CSR_PALETTE_MODE:    mode_ff <= csr_wdata[0];
            p2r_pkg::CSR_BYTES_PER_PIXEL: bpp_ff  <= csr_wdata[2:0];
            p2r_pkg::CSR_RED_MASK:        mask_ff[p2r_pkg::CH_RED]   <= csr_wdata;
            p2r_pkg::CSR_GREEN_MASK:      mask_ff[p2r_pkg::CH_GREEN] <= csr_wdata;
            p2r_pkg::CSR_BLUE_MASK:       mask_ff[p2r_pkg::CH_BLUE]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   logic adv;
   logic in_take;
   logic out_valid_ff;

   // Advance every stage when the output slot is free or being emptied
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;
   assign in_take      = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------- palette RAM
   logic                 pal_we;
   logic                 entry_hit;
   logic                 look_hit;
   logic [NC*CW-1:0]     pal_rdata;

   assign entry_hit = ({1'b0, req_ch.entry_index} < 9'(PALETTE_DEPTH));
   assign look_hit  = ({1'b0, req_ch.pixel_word[7:0]} < 9'(PALETTE_DEPTH));
   assign pal_we    = in_take && (req_ch.opcode == p2r_pkg::OP_PALETTE_WRITE) && entry_hit;

   p2r_ram #(
      .WIDTH (NC*CW),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_ch.entry_index[PAL_AW-1:0]),
      .wdata ({req_ch.entry_blue, req_ch.entry_green, req_ch.entry_red}),
      .re    (adv),
      .raddr (req_ch.pixel_word[PAL_AW-1:0]),
      .rdata (pal_rdata)
   );

   // ---------------------------------------------------------------- stage 1: capture
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_pal_ff, s1_pal_in;
   logic           s1_hit_ff, s1_hit_in;
   logic [WW-1:0]  s1_px_ff, s1_px_in;

   // Keep pixel words only, trim to the used bytes
   always_comb begin
      s1_valid_in = in_take && (req_ch.opcode == p2r_pkg::OP_PIXEL);
      s1_pal_in   = mode_ff;
      s1_hit_in   = look_hit;
      unique case (bpp_ff)
         3'd4:    s1_px_in = req_ch.pixel_word;
         3'd3:    s1_px_in = req_ch.pixel_word & 32'h00FF_FFFF;
         3'd2:    s1_px_in = req_ch.pixel_word & 32'h0000_FFFF;
         default: s1_px_in = req_ch.pixel_word & 32'h0000_00FF;
      endcase
   end

   // ---------------------------------------------------------------- stage 2: mask runs
   logic                  s2_valid_ff;
   p2r_pkg::side_type     s2_side_ff, s2_side_in;
   logic [NC-1:0][WW-1:0] s2_field_ff, s2_field_in;
   logic [NC-1:0][WW-1:0] s2_low_ff, s2_low_in;
   logic [NC-1:0][WW-1:0] s2_high_ff, s2_high_in;

   // Isolate the lowest set bit and the top bit of the first run of each mask
   always_comb begin
      logic [WW-1:0] low;
      logic [WW-1:0] run;
      s2_side_in      = '0;
      s2_side_in.pal  = s1_pal_ff;
      s2_side_in.rgb  = s1_hit_ff ? pal_rdata : '0;
      for (int c = 0; c < NC; c++) begin
         low            = mask_ff[c] & (~mask_ff[c] + WW'(1));
         run            = mask_ff[c] & ~(mask_ff[c] + low);
         s2_low_in[c]   = low;
         s2_high_in[c]  = run & ~(run >> 1);
         s2_field_in[c] = s1_px_ff & mask_ff[c];
      end
   end

   // ---------------------------------------------------------------- stage 3: positions
   logic                  s3_valid_ff;
   p2r_pkg::side_type     s3_side_ff, s3_side_in;
   logic [NC-1:0][WW-1:0] s3_field_ff;
   logic [NC-1:0][PW-1:0] s3_lsb_ff, s3_lsb_in;
   logic [NC-1:0][PW-1:0] s3_msb_ff, s3_msb_in;

   // Encode run edges to bit positions, flag empty masks
   always_comb begin
      s3_side_in = s2_side_ff;
      for (int c = 0; c < NC; c++) begin
         s3_lsb_in[c]       = p2r_pkg::onehot_to_pos(s2_low_ff[c]);
         s3_msb_in[c]       = p2r_pkg::onehot_to_pos(s2_high_ff[c]);
         s3_side_in.zero[c] = (s2_low_ff[c] == '0);
      end
   end

   // ---------------------------------------------------------------- stage 4: align
   logic                  s4_valid_ff;
   p2r_pkg::side_type     s4_side_ff, s4_side_in;
   logic [NC-1:0][WW-1:0] s4_field_ff, s4_field_in;
   logic [NC-1:0][TW-1:0] s4_top_ff, s4_top_in;

   // Cut wide fields to their top byte; right-align narrow fields and build 2^run-1
   always_comb begin
      logic [PW-1:0] span;
      logic [3:0]    run_n;
      s4_side_in = s3_side_ff;
      for (int c = 0; c < NC; c++) begin
         span               = s3_msb_ff[c] - s3_lsb_ff[c];
         run_n              = 4'(span[2:0]) + 4'd1;
         s4_side_in.wide[c] = (span >= PW'(CW - 1));
         s4_side_in.wres[c] = CW'(s3_field_ff[c] >> (s3_msb_ff[c] - PW'(CW - 1)));
         s4_field_in[c]     = s3_field_ff[c] >> s3_lsb_ff[c];
         s4_top_in[c]       = ~({TW{1'b1}} << run_n);
      end
   end

   // ---------------------------------------------------------------- divider stages
   // Stage 0 holds the rounded dividend; stages 1..DS each retire DB quotient bits.
   logic                  dv_valid_ff [DS+1];
   p2r_pkg::side_type     dv_side_ff  [DS+1];
   logic [NC-1:0][WW-1:0] dv_num_ff   [DS+1];
   logic [NC-1:0][WW-1:0] dv_num_in   [DS+1];
   logic [NC-1:0][TW-1:0] dv_rem_ff   [DS+1];
   logic [NC-1:0][TW-1:0] dv_rem_in   [DS+1];
   logic [NC-1:0][CW-1:0] dv_quo_ff   [DS+1];
   logic [NC-1:0][CW-1:0] dv_quo_in   [DS+1];
   logic [NC-1:0][TW-1:0] dv_top_ff   [DS+1];

   // Form field*255 + top/2 with 32-bit wrap, then divide by top bit by bit
   always_comb begin
      logic [TW:0]   r;
      logic [TW-1:0] rem;
      logic [CW-1:0] quo;
      logic [WW-1:0] num;
      for (int c = 0; c < NC; c++) begin
         dv_num_in[0][c] = (s4_field_ff[c] << CW) - s4_field_ff[c]
                           + WW'(s4_top_ff[c] >> 1);
         dv_rem_in[0][c] = '0;
         dv_quo_in[0][c] = '0;
      end
      for (int d = 1; d <= DS; d++) begin
         for (int c = 0; c < NC; c++) begin
            rem = dv_rem_ff[d-1][c];
            quo = dv_quo_ff[d-1][c];
            num = dv_num_ff[d-1][c];
            for (int b = 0; b < DB; b++) begin
               r   = {rem, num[WW-1]};
               num = num << 1;
               if (r >= {1'b0, dv_top_ff[d-1][c]}) begin
                  r   = r - {1'b0, dv_top_ff[d-1][c]};
                  quo = {quo[CW-2:0], 1'b1};
               end else begin
                  quo = {quo[CW-2:0], 1'b0};
               end
               rem = r[TW-1:0];
            end
            dv_num_in[d][c] = num;
            dv_rem_in[d][c] = rem;
            dv_quo_in[d][c] = quo;
         end
      end
   end

   // ---------------------------------------------------------------- output select
   logic [NC-1:0][CW-1:0] out_rgb_ff, out_rgb_in;

   // Pick palette, zero, cut or scaled value per channel
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         priority if (dv_side_ff[DS].pal) begin
            out_rgb_in[c] = dv_side_ff[DS].rgb[c];
         end else if (dv_side_ff[DS].zero[c]) begin
            out_rgb_in[c] = '0;
         end else if (dv_side_ff[DS].wide[c]) begin
            out_rgb_in[c] = dv_side_ff[DS].wres[c];
         end else begin
            out_rgb_in[c] = dv_quo_ff[DS][c];
         end
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.red_out   = out_rgb_ff[p2r_pkg::CH_RED];
   assign rsp_ch.green_out = out_rgb_ff[p2r_pkg::CH_GREEN];
   assign rsp_ch.blue_out  = out_rgb_ff[p2r_pkg::CH_BLUE];

   // ---------------------------------------------------------------- valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         for (int d = 0; d <= DS; d++) begin
            dv_valid_ff[d] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
         dv_valid_ff[0] <= s4_valid_ff;
         for (int d = 1; d <= DS; d++) begin
            dv_valid_ff[d] <= dv_valid_ff[d-1];
         end
         out_valid_ff   <= dv_valid_ff[DS];
      end
   end

   // ---------------------------------------------------------------- payload chain
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pal_ff   <= s1_pal_in;
         s1_hit_ff   <= s1_hit_in;
         s1_px_ff    <= s1_px_in;

         s2_side_ff  <= s2_side_in;
         s2_field_ff <= s2_field_in;
         s2_low_ff   <= s2_low_in;
         s2_high_ff  <= s2_high_in;

         s3_side_ff  <= s3_side_in;
         s3_field_ff <= s2_field_ff;
         s3_lsb_ff   <= s3_lsb_in;
         s3_msb_ff   <= s3_msb_in;

         s4_side_ff  <= s4_side_in;
         s4_field_ff <= s4_field_in;
         s4_top_ff   <= s4_top_in;

         dv_side_ff[0] <= s4_side_ff;
         dv_top_ff[0]  <= s4_top_ff;
         for (int d = 0; d <= DS; d++) begin
            dv_num_ff[d] <= dv_num_in[d];
            dv_rem_ff[d] <= dv_rem_in[d];
            dv_quo_ff[d] <= dv_quo_in[d];
         end
         for (int d = 1; d <= DS; d++) begin
            dv_side_ff[d] <= dv_side_ff[d-1];
            dv_top_ff[d]  <= dv_top_ff[d-1];
         end

         out_rgb_ff <= out_rgb_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   // A pixel word taken on an open pipeline shows up in stage 1 on the next edge
   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.opcode == p2r_pkg::OP_PIXEL) |=> s1_valid_ff)
      else $error("pixel word lost at pipeline entry");

   // A palette write never produces a response slot
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.opcode == p2r_pkg::OP_PALETTE_WRITE)
      |=> !s1_valid_ff)
      else $error("palette write entered the pixel pipeline");

   // Mask runs never end below where they start
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_side_ff.zero[0] || s3_msb_ff[0] >= s3_lsb_ff[0])
                   && (s3_side_ff.zero[1] || s3_msb_ff[1] >= s3_lsb_ff[1])
                   && (s3_side_ff.zero[2] || s3_msb_ff[2] >= s3_lsb_ff[2]))
      else $error("mask run end below run start");

   // The divider remainder stays below the divisor for scaled channels
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[DS] && !dv_side_ff[DS].pal |->
         (dv_side_ff[DS].zero[0] || dv_side_ff[DS].wide[0]
          || dv_rem_ff[DS][0] < dv_top_ff[DS][0])
      && (dv_side_ff[DS].zero[1] || dv_side_ff[DS].wide[1]
          || dv_rem_ff[DS][1] < dv_top_ff[DS][1])
      && (dv_side_ff[DS].zero[2] || dv_side_ff[DS].wide[2]
          || dv_rem_ff[DS][2] < dv_top_ff[DS][2]))
      else $error("divider remainder not below divisor");

endmodule

// ===== dv/tb_pixel_to_rgb888_converter_top.sv =====
// Self-checking testbench of the pixel to RGB888 converter: mask decode and palette lookup.
module tb_pixel_to_rgb888_converter_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One request word as the driver offers it
   typedef struct packed {
      logic        opcode;
      logic [31:0] pixel_word;
      logic [7:0]  entry_index;
      logic [7:0]  entry_red;
      logic [7:0]  entry_green;
      logic [7:0]  entry_blue;
   } pixel_item_type;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 96;
   localparam int MAX_REPORTS   = 60;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [p2r_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [p2r_pkg::CSR_DATA_W-1:0] csr_wdata;

   p2r_req_if req_ch ();
   p2r_rsp_if rsp_ch ();

   pixel_to_rgb888_converter_top #(
      .PALETTE_DEPTH(256)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4ns clock = ~clock;

   // Predictor state: register copy and palette contents
   logic        cfg_palette_mode;
   logic [2:0]  cfg_bytes_per_pixel;
   logic [31:0] cfg_red_mask;
   logic [31:0] cfg_green_mask;
   logic [31:0] cfg_blue_mask;
   logic [23:0] palette_copy [256] = '{default: '0};

   // Stimulus bookkeeping: which palette entries have been queued for loading so far
   logic        entry_loaded [256];
   logic [7:0]  loaded_entries_q [$];

   pixel_item_type pixel_items_q [$];
   logic [23:0]    rgb_expected_q [$];

   int error_count    = 0;
   int report_count   = 0;
   int pixels_seen    = 0;
   int entries_taken  = 0;
   int settings_count = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int burst_left     = 0;
   int gap_left       = 0;
   int cycle_count    = 0;
   int stall_mode     = 0;

   // Decode one channel from its mask: top 8 bits of a wide field, rounded scale of a narrow one
   function automatic logic [7:0] decode_field(input logic [31:0] px, input logic [31:0] mask);
      int unsigned lsb;
      int unsigned run;
      logic [31:0] field;
      logic [31:0] top;
      logic [31:0] scaled;
      if (mask == '0) begin
         return 8'h00;
      end
      lsb = 0;
      while (lsb < 32 && !mask[lsb]) lsb++;
      run = 0;
      while (lsb + run < 32 && mask[lsb + run]) run++;
      field = (px & mask) >> lsb;
      if (run >= 8) begin
         return 8'(field >> (run - 8));
      end
      top    = (32'd1 << run) - 32'd1;
      scaled = field * 32'd255 + top / 32'd2;
      return 8'(scaled / top);
   endfunction

   // Expected {red, green, blue} of a pixel word under the current settings
   function automatic logic [23:0] convert_pixel(input logic [31:0] word);
      logic [31:0] px;
      if (cfg_palette_mode) begin
         return palette_copy[word[7:0]];
      end
      case (cfg_bytes_per_pixel)
         3'd4: px = word;
         3'd3: px = word & 32'h00FF_FFFF;
         3'd2: px = word & 32'h0000_FFFF;
         default: px = word & 32'h0000_00FF;
      endcase
      return {decode_field(px, cfg_red_mask), decode_field(px, cfg_green_mask),
              decode_field(px, cfg_blue_mask)};
   endfunction

   // Account for one accepted word: load the palette or expect a converted pixel
   function automatic void absorb_word(input pixel_item_type taken);
      if (taken.opcode == p2r_pkg::OP_PALETTE_WRITE) begin
         palette_copy[taken.entry_index] = {taken.entry_red, taken.entry_green, taken.entry_blue};
         entries_taken++;
      end else begin
         rgb_expected_q.push_back(convert_pixel(taken.pixel_word));
      end
   endfunction

   // Driver: offer queued words in bursts with random gaps
   always @(posedge clock) begin : drive_words
      pixel_item_type taken;
      pixel_item_type next_word;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.opcode      <= p2r_pkg::OP_PIXEL;
         req_ch.pixel_word  <= '0;
         req_ch.entry_index <= '0;
         req_ch.entry_red   <= '0;
         req_ch.entry_green <= '0;
         req_ch.entry_blue  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.opcode      = req_ch.opcode;
            taken.pixel_word  = req_ch.pixel_word;
            taken.entry_index = req_ch.entry_index;
            taken.entry_red   = req_ch.entry_red;
            taken.entry_green = req_ch.entry_green;
            taken.entry_blue  = req_ch.entry_blue;
            absorb_word(taken);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pixel_items_q.size() > 0) begin
               next_word = pixel_items_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= next_word.opcode;
               req_ch.pixel_word  <= next_word.pixel_word;
               req_ch.entry_index <= next_word.entry_index;
               req_ch.entry_red   <= next_word.entry_red;
               req_ch.entry_green <= next_word.entry_green;
               req_ch.entry_blue  <= next_word.entry_blue;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response word and stall the response channel
   always @(posedge clock) begin : check_words
      logic [23:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            pixels_seen++;
            if (rgb_expected_q.size() == 0) begin
               error_count++;
               if (report_count++ < MAX_REPORTS) begin
                  $display("%0t ns: unexpected rgb word, expected none, got %02h %02h %02h",
                           $time, rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
               end
            end else begin
               want = rgb_expected_q.pop_front();
               if (rsp_ch.red_out !== want[23:16]) begin
                  error_count++;
                  if (report_count++ < MAX_REPORTS) begin
                     $display("%0t ns: red_out mismatch, expected %02h, got %02h",
                              $time, want[23:16], rsp_ch.red_out);
                  end
               end
               if (rsp_ch.green_out !== want[15:8]) begin
                  error_count++;
                  if (report_count++ < MAX_REPORTS) begin
                     $display("%0t ns: green_out mismatch, expected %02h, got %02h",
                              $time, want[15:8], rsp_ch.green_out);
                  end
               end
               if (rsp_ch.blue_out !== want[7:0]) begin
                  error_count++;
                  if (report_count++ < MAX_REPORTS) begin
                     $display("%0t ns: blue_out mismatch, expected %02h, got %02h",
                              $time, want[7:0], rsp_ch.blue_out);
                  end
               end
            end
         end
         // Periodically pick a new stall pattern
         if (cycle_count % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && pixels_seen >= 300 && pixel_items_q.size() > 40) begin
            // Hold off long enough for the pipeline to fill and back up the request side
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= (cycle_count % 3 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic queue_pixel(input logic [31:0] word);
      pixel_item_type it;
      it = '0;
      it.opcode     = p2r_pkg::OP_PIXEL;
      it.pixel_word = word;
      pixel_items_q.push_back(it);
   endtask

   task automatic queue_entry(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
      pixel_item_type it;
      it.opcode      = p2r_pkg::OP_PALETTE_WRITE;
      it.pixel_word  = $urandom();
      it.entry_index = idx;
      it.entry_red   = r;
      it.entry_green = g;
      it.entry_blue  = b;
      pixel_items_q.push_back(it);
      if (!entry_loaded[idx]) begin
         entry_loaded[idx] = 1'b1;
         loaded_entries_q.push_back(idx);
      end
   endtask

   // Wait until every word is taken and every response is back, then let the pipeline empty
   task automatic settle();
      while (pixel_items_q.size() > 0 || req_ch.valid || rgb_expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [p2r_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all five registers and mirror them in the predictor
   task automatic apply_settings(input logic pm, input logic [2:0] bpp, input logic [31:0] rm,
                                 input logic [31:0] gm, input logic [31:0] bm);
      write_csr(p2r_pkg::CSR_PALETTE_MODE, 32'(pm));
      write_csr(p2r_pkg::CSR_BYTES_PER_PIXEL, 32'(bpp));
      write_csr(p2r_pkg::CSR_RED_MASK, rm);
      write_csr(p2r_pkg::CSR_GREEN_MASK, gm);
      write_csr(p2r_pkg::CSR_BLUE_MASK, bm);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_palette_mode    = pm;
      cfg_bytes_per_pixel = bpp;
      cfg_red_mask        = rm;
      cfg_green_mask      = gm;
      cfg_blue_mask       = bm;
      settings_count++;
   endtask

   function automatic logic [31:0] random_mask();
      int unsigned w;
      int unsigned pos;
      logic [63:0] run_a;
      logic [63:0] run_b;
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3: begin
            w     = $urandom_range(1, 12);
            pos   = $urandom_range(0, 32 - w);
            run_a = ((64'd1 << w) - 64'd1) << pos;
            return run_a[31:0];
         end
         4: return 32'd1 << $urandom_range(0, 31);
         5: begin
            // Two runs with a gap between them
            w     = $urandom_range(1, 7);
            pos   = $urandom_range(0, 16);
            run_a = ((64'd1 << w) - 64'd1) << pos;
            run_b = ((64'd1 << $urandom_range(1, 8)) - 64'd1) << (pos + w + $urandom_range(1, 8));
            return run_a[31:0] | run_b[31:0];
         end
         6: begin
            w     = $urandom_range(8, 32);
            pos   = $urandom_range(0, 32 - w);
            run_a = ((64'd1 << w) - 64'd1) << pos;
            return run_a[31:0];
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Stimulus and end of run
   initial begin : run_test
      logic       pm;
      logic [2:0] bpp;
      int         n_load;
      logic [7:0] pick;

      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      cfg_palette_mode    = 1'b0;
      cfg_bytes_per_pixel = p2r_pkg::BPP_RESET;
      cfg_red_mask        = p2r_pkg::RED_MASK_RESET;
      cfg_green_mask      = p2r_pkg::GREEN_MASK_RESET;
      cfg_blue_mask       = p2r_pkg::BLUE_MASK_RESET;
      foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: plain 8:8:8 in the low three bytes
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h0012_3456);
      queue_pixel(32'hA5C3_0F81);
      settle();

      // Full-width mask, zero mask, single top bit
      apply_settings(1'b0, 3'd4, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h8000_0000);
      queue_pixel(32'h7F00_0000);
      settle();

      // 5:6:5 narrow fields on two bytes, upper bytes dropped
      apply_settings(1'b0, 3'd2, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
      queue_pixel(32'h0000_FFFF);
      queue_pixel(32'h0000_0000);
      queue_pixel(32'h0000_8410);
      queue_pixel(32'hFFFF_0001);
      settle();

      // Gapped masks, where the narrow product wraps
      apply_settings(1'b0, 3'd4, 32'h0F0F_0000, 32'h0000_0003, 32'h8000_0001);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h0F0F_0003);
      queue_pixel(32'h8001_0002);
      settle();

      // Out-of-range byte count keeps only the low byte
      apply_settings(1'b0, 3'd7, 32'h0000_FF00, 32'h8000_0001, 32'h0000_00FF);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h1234_5600);
      settle();

      // Palette: load the end entries, look them up, reload and look up again
      apply_settings(1'b1, 3'd1, p2r_pkg::RED_MASK_RESET, p2r_pkg::GREEN_MASK_RESET,
                     p2r_pkg::BLUE_MASK_RESET);
      queue_entry(8'h00, 8'h00, 8'h00, 8'h00);
      queue_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_entry(8'h5A, 8'h12, 8'h34, 8'h56);
      queue_pixel(32'hFFFF_FF00);
      queue_pixel(32'h0000_00FF);
      queue_pixel(32'h0000_005A);
      queue_entry(8'h00, 8'hA5, 8'h5A, 8'hC3);
      queue_pixel(32'h1234_5600);
      settle();

      // Random settings, each followed by a batch of words
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pm  = (phase % 4 == 3) || ($urandom_range(0, 5) == 0);
         bpp = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
         apply_settings(pm, bpp, random_mask(), random_mask(), random_mask());
         if (pm) begin
            // Load a set of entries, then mostly look up loaded ones
            n_load = $urandom_range(4, 24);
            for (int i = 0; i < n_load; i++) begin
               queue_entry(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
            end
            for (int i = n_load; i < PHASE_ITEMS; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  queue_entry(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
               end else begin
                  pick = loaded_entries_q[$urandom_range(0, loaded_entries_q.size() - 1)];
                  queue_pixel({24'($urandom()), pick});
               end
            end
         end else begin
            for (int i = 0; i < PHASE_ITEMS; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  queue_entry(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
               end else begin
                  queue_pixel(random_pixel());
               end
            end
         end
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d converted pixels and %0d palette loads over %0d register settings.",
               pixels_seen, entries_taken, settings_count);
      $display("Long response hold-off exercised: %0d, mismatches: %0d.", hold_done, error_count);
      if (error_count == 0 && rgb_expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin : watchdog
      #2_000_000;
      $display("Run timed out with %0d responses outstanding.", rgb_expected_q.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ===== pixel_to_rgb888_converter_top.f =====
hdl/p2r_pkg.sv
hdl/p2r_ifaces.sv
hdl/p2r_ram.sv
hdl/pixel_to_rgb888_converter_top.sv
dv/tb_pixel_to_rgb888_converter_top.sv
